@@ design/per_client_token_bucket_limiter_top_defines.svh @@
// Assertion macros used by the token bucket limiter checker.
`ifndef PER_CLIENT_TOKEN_BUCKET_LIMITER_TOP_DEFINES_SVH
`define PER_CLIENT_TOKEN_BUCKET_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PTBL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PTBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PTBL_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ptbl_pkg.sv @@
// Types and constants of the per-client token bucket limiter.
package ptbl_pkg;

    localparam int NUM_CLIENTS_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int REQ_W    = 3;
    localparam int CLIENT_W = 8;
    localparam int TIME_W   = 32;
    localparam int RATE_W   = 32;
    localparam int BURST_W  = 16;
    localparam int TOKEN_W  = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_REQUEST   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_RATE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_BURST = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESET     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd4;

    localparam logic [0:0] REG_DEFAULT_RATE  = 1'b0;
    localparam logic [0:0] REG_DEFAULT_BURST = 1'b1;

    localparam logic [RATE_W-1:0]  DEFAULT_RATE_RST  = 32'd6554;
    localparam logic [BURST_W-1:0] DEFAULT_BURST_RST = 16'd10;

    typedef struct packed {
        logic               valid;
        logic [TOKEN_W-1:0] tokens;
        logic [RATE_W-1:0]  rate;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  last_ms;
    } t_bucket;

    // Capacity in fixed point, saturated to the token width.
    function automatic logic [TOKEN_W-1:0] f_cap_fixed(input logic [BURST_W-1:0] burst,
                                                       input int frac_bits);
        logic [47:0] wide;
        wide = 48'(burst) << frac_bits;
        return (|wide[47:TOKEN_W]) ? '1 : wide[TOKEN_W-1:0];
    endfunction

endpackage

@@ design/per_client_token_bucket_limiter_top.sv @@
// Per-client token bucket limiter: bucket table in one memory, read-modify-write per item.
// Each item is read from memory, then refilled and written back in S_READ and S_CALC.
// A new item is taken in S_IDLE, or in S_CALC as the last one writes back its result.
// A back-to-back item on the same client is served by forwarding the last write.
// Reset clears the control registers and then sweeps the table,
// one entry per cycle, with input stalled; configuration writes are taken meanwhile.
module per_client_token_bucket_limiter_top #(
    parameter int NUM_CLIENTS = ptbl_pkg::NUM_CLIENTS_DEF,
    parameter int FRAC_BITS   = ptbl_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ptbl_pkg::REQ_W-1:0]         i_req_type,
    input  logic [ptbl_pkg::CLIENT_W-1:0]      i_client,
    input  logic [ptbl_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [ptbl_pkg::RATE_W-1:0]        i_rate_value,
    input  logic [ptbl_pkg::BURST_W-1:0]       i_burst_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_allowed,
    output logic [ptbl_pkg::TOKEN_W-1:0]       o_tokens_left,
    output logic                               o_entry_present,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptbl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ptbl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ptbl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import ptbl_pkg::*;

    localparam int IDX_W = $clog2(NUM_CLIENTS);
    localparam logic [TOKEN_W-1:0] ONE_TOKEN = TOKEN_W'(64'd1 << FRAC_BITS);

    typedef logic [IDX_W-1:0] t_idx_lut [256];

    function automatic t_idx_lut f_idx_lut();
        t_idx_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = IDX_W'(i % NUM_CLIENTS);
        end
        return lut;
    endfunction

    localparam t_idx_lut IDX_LUT = f_idx_lut();

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CALC} t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [IDX_W-1:0]     r_idx;
    logic [REQ_W-1:0]     r_req;
    logic [TIME_W-1:0]    r_now;
    logic [RATE_W-1:0]    r_rate_in;
    logic [BURST_W-1:0]   r_burst_in;
    logic                 r_fwd;
    t_bucket              r_wr_word;
    t_bucket              r_rdata;
    t_bucket              r_word;
    logic [63:0]          r_prod;
    logic                 r_out_valid;
    logic                 r_out_allowed;
    logic [TOKEN_W-1:0]   r_out_tokens;
    logic                 r_out_present;
    logic [RATE_W-1:0]    r_default_rate;
    logic [BURST_W-1:0]   r_default_burst;
    t_bucket              r_mem [NUM_CLIENTS];

    logic                 in_accept;
    logic                 out_free;
    logic                 cfg_write;
    logic [IDX_W-1:0]     in_idx;
    t_bucket              rd_word;
    t_bucket              new_word;
    t_bucket              e_word;
    logic                 creating;
    logic [TIME_W-1:0]    elapsed;
    logic [63:0]          prod;
    logic [TOKEN_W-1:0]   cap_fix;
    logic [TOKEN_W-1:0]   burst_fix;
    logic [64:0]          level;
    logic [TOKEN_W-1:0]   sat;
    logic                 grant;
    t_bucket              n_word;
    logic                 n_allowed;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    t_bucket              mem_wdata;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_CALC) && out_free));
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_idx     = IDX_LUT[i_client];
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_comb begin
        case (paddr[2:2])
            REG_DEFAULT_RATE:  prdata = r_default_rate;
            REG_DEFAULT_BURST: prdata = APB_DATA_W'(r_default_burst);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        rd_word  = r_fwd ? r_wr_word : r_rdata;
        creating = !rd_word.valid && ((r_req == REQ_REQUEST) || (r_req == REQ_SET_RATE) ||
                                      (r_req == REQ_SET_BURST));
        new_word.valid   = 1'b1;
        new_word.rate    = (r_req == REQ_SET_RATE) ? r_rate_in : r_default_rate;
        new_word.burst   = (r_req == REQ_SET_BURST) ? r_burst_in : r_default_burst;
        new_word.tokens  = f_cap_fixed(new_word.burst, FRAC_BITS);
        new_word.last_ms = r_now;
        e_word  = creating ? new_word : rd_word;
        elapsed = r_now - e_word.last_ms;
        prod    = 64'(elapsed) * 64'(e_word.rate);
    end

    always_comb begin
        cap_fix   = f_cap_fixed(r_word.burst, FRAC_BITS);
        burst_fix = f_cap_fixed(r_burst_in, FRAC_BITS);
        level     = 65'(r_word.tokens) + 65'(r_prod);
        sat       = (level > 65'(cap_fix)) ? cap_fix : level[TOKEN_W-1:0];
        grant     = (sat >= ONE_TOKEN);
        n_word    = r_word;
        n_allowed = 1'b0;
        case (r_req)
            REQ_REQUEST: begin
                n_word.tokens  = grant ? (sat - ONE_TOKEN) : sat;
                n_word.last_ms = r_now;
                n_allowed      = grant;
            end
            REQ_SET_RATE: begin
                n_word.rate = r_rate_in;
            end
            REQ_SET_BURST: begin
                n_word.burst = r_burst_in;
                if (r_word.tokens > burst_fix) begin
                    n_word.tokens = burst_fix;
                end
            end
            REQ_RESET: begin
                n_word.valid = 1'b0;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    assign mem_we    = (r_state == S_CLEAR) || ((r_state == S_CALC) && out_free);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_idx;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : n_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rdata <= r_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_idx       <= '0;
            r_fwd           <= 1'b0;
            r_out_valid     <= 1'b0;
            r_default_rate  <= DEFAULT_RATE_RST;
            r_default_burst <= DEFAULT_BURST_RST;
        end else begin
            if (cfg_write) begin
                case (paddr[2:2])
                    REG_DEFAULT_RATE:  r_default_rate  <= pwdata;
                    REG_DEFAULT_BURST: r_default_burst <= pwdata[BURST_W-1:0];
                    default:           r_default_rate  <= r_default_rate;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_CALC)) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                r_idx      <= in_idx;
                r_req      <= i_req_type;
                r_now      <= i_now_ms;
                r_rate_in  <= i_rate_value;
                r_burst_in <= i_burst_value;
                r_fwd      <= (r_state == S_CALC) && (in_idx == r_idx);
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(NUM_CLIENTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_word  <= e_word;
                    r_prod  <= prod;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_allowed <= n_allowed;
                        r_out_tokens  <= n_word.valid ? n_word.tokens : '0;
                        r_out_present <= n_word.valid;
                        r_wr_word     <= n_word;
                        r_state       <= in_accept ? S_READ : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_allowed       = r_out_allowed;
    assign o_tokens_left   = r_out_tokens;
    assign o_entry_present = r_out_present;

endmodule

@@ design/ptbl_checker.sv @@
// Port-level checker for the token bucket limiter and its bind.
`include "per_client_token_bucket_limiter_top_defines.svh"

module ptbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_allowed,
    input logic [31:0] o_tokens_left
);

    `PTBL_ASSERT_ALWAYS(a_reset_stalls, !i_rst_n, o_in_stall, "input not stalled after reset")
    `PTBL_ASSERT_NEXT(a_one_at_a_time, i_in_valid && !o_in_stall, o_in_stall, "item taken too soon")
    `PTBL_ASSERT_NOW(a_result_latency, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 3), "result without item")
    `PTBL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_tokens_left) && $stable(o_allowed), "stalled result changed")

endmodule

bind per_client_token_bucket_limiter_top ptbl_checker u_ptbl_checker (.*);
